// ===== design/sata_read_command_builder_core_macros.svh =====
// Assertion macros used by the checker file of the read command builder.
`ifndef SATA_READ_COMMAND_BUILDER_CORE_MACROS_SVH
`define SATA_READ_COMMAND_BUILDER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define SRCB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define SRCB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/srcb_pkg.sv =====
// Shared types, constants and sizes of the read command builder.
package srcb_pkg;

  localparam int MAX_SG_ENTRIES    = 8;
  localparam int SECTORS_PER_ENTRY = 16;
  localparam int SLOT_COUNT        = 32;
  localparam int SECTOR_BYTES      = 512;
  localparam int QUEUE_DEPTH       = 2;

  localparam int ENTRY_W = $clog2(MAX_SG_ENTRIES + 1);
  localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

  localparam int MAX_SECTORS = MAX_SG_ENTRIES * SECTORS_PER_ENTRY;
  localparam logic [63:0] ENTRY_BYTES = 64'(SECTORS_PER_ENTRY * SECTOR_BYTES);
  localparam logic [12:0] FULL_BCM1   = 13'(SECTORS_PER_ENTRY * SECTOR_BYTES - 1);

  localparam logic [1:0] ITEM_ENTRY   = 2'd0;
  localparam logic [1:0] ITEM_COMMAND = 2'd1;
  localparam logic [1:0] ITEM_ERROR   = 2'd2;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_NO_SLOT = 2'd1;
  localparam logic [1:0] ERR_COUNT   = 2'd2;

  localparam logic [7:0]  OP_READ_DMA     = 8'hC8;
  localparam logic [7:0]  OP_READ_DMA_EXT = 8'h25;
  localparam logic [47:0] SHORT_LIMIT     = 48'h0000_0FFF_FFFF;
  localparam logic [7:0]  LBA_MODE_BIT    = 8'h40;
  localparam logic [3:0]  HEAD_MASK       = 4'hF;

  typedef struct packed {
    logic [47:0] start_block;
    logic [15:0] num_sectors;
    logic [63:0] buffer_address;
    logic [31:0] busy_slots;
  } req_t;

  typedef struct packed {
    logic [1:0]  item_kind;
    logic [4:0]  slot;
    logic [63:0] data_address;
    logic [12:0] byte_count_minus_one;
    logic        interrupt_on_done;
    logic [7:0]  command_code;
    logic [7:0]  device_byte;
    logic [47:0] block_out;
    logic [15:0] count_out;
    logic [1:0]  error_code;
    logic        last;
  } rsp_t;

  // Classified request as it waits between front and back.
  typedef struct packed {
    logic               is_error;
    logic [1:0]         error_code;
    logic [4:0]         slot;
    logic [63:0]        buffer_address;
    logic [47:0]        start_block;
    logic [15:0]        num_sectors;
    logic [ENTRY_W-1:0] entries;
    logic [12:0]        last_bcm1;
    logic [7:0]         command_code;
    logic [7:0]         device_byte;
  } desc_t;

endpackage

// ===== design/srcb_front.sv =====
// Front end: accept a request, pick a slot, check the count, classify.
module srcb_front (
  input  logic           req_valid,
  output logic           req_ready,
  input  srcb_pkg::req_t req_data,
  input  logic           q_full,
  output logic           push,
  output srcb_pkg::desc_t desc
);

  logic        found;
  logic [4:0]  slot_sel;
  logic [15:0] count_m1;
  logic        count_bad;
  logic [31:0] rem;

  // Lowest clear bit wins: scan from the top so the lowest assignment sticks.
  always_comb begin
    found    = 1'b0;
    slot_sel = '0;
    for (int i = srcb_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
      if (!req_data.busy_slots[i]) begin
        found    = 1'b1;
        slot_sel = 5'(i);
      end
    end
  end

  assign count_m1  = req_data.num_sectors - 16'd1;
  assign count_bad = (req_data.num_sectors == 16'd0) ||
                     (32'(req_data.num_sectors) > 32'(srcb_pkg::MAX_SECTORS));
  assign rem       = 32'(count_m1) % srcb_pkg::SECTORS_PER_ENTRY;

  always_comb begin
    desc                = '0;
    desc.buffer_address = req_data.buffer_address;
    desc.start_block    = req_data.start_block;
    desc.num_sectors    = req_data.num_sectors;
    desc.entries        = srcb_pkg::ENTRY_W'(32'(count_m1) / srcb_pkg::SECTORS_PER_ENTRY + 1);
    desc.last_bcm1      = 13'(rem * srcb_pkg::SECTOR_BYTES + (srcb_pkg::SECTOR_BYTES - 1));
    if (req_data.start_block < srcb_pkg::SHORT_LIMIT) begin
      desc.command_code = srcb_pkg::OP_READ_DMA;
      desc.device_byte  = srcb_pkg::LBA_MODE_BIT |
                          {4'h0, req_data.start_block[27:24] & srcb_pkg::HEAD_MASK};
    end else begin
      desc.command_code = srcb_pkg::OP_READ_DMA_EXT;
      desc.device_byte  = srcb_pkg::LBA_MODE_BIT;
    end
    priority if (!found) begin
      desc.is_error   = 1'b1;
      desc.error_code = srcb_pkg::ERR_NO_SLOT;
    end else if (count_bad) begin
      desc.is_error   = 1'b1;
      desc.error_code = srcb_pkg::ERR_COUNT;
      desc.slot       = slot_sel;
    end else begin
      desc.is_error   = 1'b0;
      desc.error_code = srcb_pkg::ERR_NONE;
      desc.slot       = slot_sel;
    end
  end

  assign req_ready = !q_full;
  assign push      = req_valid && !q_full;

endmodule

// ===== design/srcb_queue.sv =====
// Short request queue between the front and back ends.
module srcb_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  srcb_pkg::desc_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output srcb_pkg::desc_t head
);

  srcb_pkg::desc_t                    store [srcb_pkg::QUEUE_DEPTH];
  logic [srcb_pkg::QPTR_W-1:0] wr_ptr;
  logic [srcb_pkg::QPTR_W-1:0] rd_ptr;
  logic [srcb_pkg::QCNT_W-1:0] count;

  assign full       = (count == srcb_pkg::QCNT_W'(srcb_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == srcb_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (32'(rd_ptr) == srcb_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/srcb_back.sv =====
// Back end: walk one queued request and emit its entries and command frame, or its error item.
module srcb_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  srcb_pkg::desc_t head,
  output logic            pop,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output srcb_pkg::rsp_t  rsp_data
);

  logic [srcb_pkg::ENTRY_W-1:0] idx;
  logic [63:0]                  addr_acc;
  logic                         out_free;
  logic                         fire;
  logic                         at_command;
  logic                         at_last_entry;
  logic [63:0]                  entry_addr;
  srcb_pkg::rsp_t               item;

  assign out_free      = !rsp_valid || rsp_ready;
  assign fire          = head_valid && out_free;
  assign at_command    = (idx == head.entries);
  assign at_last_entry = (srcb_pkg::ENTRY_W'(idx + 1'b1) == head.entries);
  assign entry_addr    = (idx == '0) ? head.buffer_address : addr_acc;
  assign pop           = fire && (head.is_error || at_command);

  always_comb begin
    item      = '0;
    item.last = 1'b1;
    priority if (head.is_error) begin
      item.item_kind  = srcb_pkg::ITEM_ERROR;
      item.error_code = head.error_code;
    end else if (at_command) begin
      item.item_kind    = srcb_pkg::ITEM_COMMAND;
      item.slot         = head.slot;
      item.command_code = head.command_code;
      item.device_byte  = head.device_byte;
      item.block_out    = head.start_block;
      item.count_out    = head.num_sectors;
      item.error_code   = srcb_pkg::ERR_NONE;
    end else begin
      item.item_kind            = srcb_pkg::ITEM_ENTRY;
      item.slot                 = head.slot;
      item.data_address         = entry_addr;
      item.byte_count_minus_one = at_last_entry ? head.last_bcm1 : srcb_pkg::FULL_BCM1;
      item.interrupt_on_done    = 1'b1;
      item.last                 = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (out_free) begin
        rsp_valid <= head_valid;
      end
      if (fire) begin
        idx <= pop ? '0 : idx + 1'b1;
      end
    end
  end

  // Payload registers: hold until the next item is loaded.
  always_ff @(posedge clk) begin
    if (fire) begin
      rsp_data <= item;
      addr_acc <= entry_addr + srcb_pkg::ENTRY_BYTES;
    end
  end

endmodule

// ===== design/sata_read_command_builder_core.sv =====
// Top level of the SATA read command builder (front end, request queue, back end).
// A request is written into the queue, and its results are registered in the back end output register.
// A good request gives N entries plus one command frame, at one result per cycle through
// the back end output register while rsp_ready is high; an error gives 1.
// The front end accepts one request per cycle while the 2-deep queue has room.
// Reset (rst, synchronous): empty the queue, drop rsp_valid, rewind the entry index.
module sata_read_command_builder_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  srcb_pkg::req_t  req_data,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output srcb_pkg::rsp_t  rsp_data
);

  // Classified transaction from the front end, pushed into the queue.
  logic            push;
  srcb_pkg::desc_t push_desc;
  logic            q_full;

  // Queue head as seen by the back end.
  logic            head_valid;
  srcb_pkg::desc_t head;
  logic            pop;

  // Front end: pick the lowest free slot, check the sector count and
  // settle the opcode and device byte, all in the accept cycle.
  srcb_front u_front (
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .q_full    (q_full),
    .push      (push),
    .desc      (push_desc)
  );

  // Queue: decouple accepting new transactions from draining results, so
  // a stalled rsp side does not block the next request until it fills.
  srcb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_desc),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Back end: step through the scatter-gather entries of the head request,
  // advancing the buffer address per entry, then emit the command frame and
  // pop. Error requests leave as a single item.
  srcb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp_data   (rsp_data)
  );

endmodule

// ===== design/srcb_checker.sv =====
// Port-level checks of the read command builder, bound to its top level.
`include "sata_read_command_builder_core_macros.svh"

module srcb_checker (
  input logic           clk,
  input logic           rst,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input srcb_pkg::rsp_t rsp_data
);

  logic rsp_stall;
  logic rsp_fire;
  logic err_item;
  logic err_ok;
  logic ent_item;
  logic ent_ok;

  assign rsp_stall = rsp_valid && !rsp_ready;
  assign rsp_fire  = rsp_valid && rsp_ready;
  assign err_item  = rsp_valid && (rsp_data.item_kind == srcb_pkg::ITEM_ERROR);
  assign err_ok    = rsp_data.last && (rsp_data.slot == 5'd0) &&
                     (rsp_data.error_code != srcb_pkg::ERR_NONE);
  assign ent_item  = rsp_valid && (rsp_data.item_kind == srcb_pkg::ITEM_ENTRY);
  assign ent_ok    = rsp_data.interrupt_on_done && !rsp_data.last;

  `SRCB_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_data), "stalled result moved")
  `SRCB_ASSERT_SAME(a_error_last, err_item, err_ok, "malformed error item")
  `SRCB_ASSERT_SAME(a_entry_form, ent_item, ent_ok, "malformed entry item")
  `SRCB_ASSERT_NEXT(a_entry_follow, rsp_fire && ent_item, rsp_valid, "gap after an entry item")

endmodule

bind sata_read_command_builder_core srcb_checker u_srcb_checker (.*);
